FILE: rtl/core/lvs_pkg.sv
// Package: widths, handshake structs and shared types for the 3D line voxel stepper.
`default_nettype none

package lvs_pkg;

  // Field width on the ports, and the grid side used by the arithmetic
  localparam int unsigned FIELD_W    = 6;
  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned ERR_W      = COORD_BITS + 2;
  localparam int unsigned NUM_AXES   = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [FIELD_W-1:0] z;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] x;
  } point_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the endpoints
    logic setup;  // derive differences, major axis and count
    logic step;   // advance one voxel into the output register
  } lvs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_empty; // valid during setup: nothing lies between the points
    logic last_step;  // the next step produces the final voxel
    logic out_free;   // output register can take a voxel this cycle
  } lvs_sts_t;

endpackage : lvs_pkg

`default_nettype wire

FILE: rtl/core/lvs_if.sv
// Interfaces: endpoint input channel and voxel output channel.
`default_nettype none

interface lvs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lvs_pkg::FIELD_W-1:0] end_x;
  logic [lvs_pkg::FIELD_W-1:0] end_y;
  logic [lvs_pkg::FIELD_W-1:0] end_z;
  logic [lvs_pkg::FIELD_W-1:0] start_x;
  logic [lvs_pkg::FIELD_W-1:0] start_y;
  logic [lvs_pkg::FIELD_W-1:0] start_z;

  modport source (output valid, end_x, end_y, end_z, start_x, start_y, start_z,
                  input ready);
  modport sink   (input valid, end_x, end_y, end_z, start_x, start_y, start_z,
                  output ready);
endinterface : lvs_in_if

interface lvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lvs_pkg::FIELD_W-1:0] voxel_x;
  logic [lvs_pkg::FIELD_W-1:0] voxel_y;
  logic [lvs_pkg::FIELD_W-1:0] voxel_z;
  logic                        last_voxel;

  modport source (output valid, voxel_x, voxel_y, voxel_z, last_voxel, input ready);
  modport sink   (input valid, voxel_x, voxel_y, voxel_z, last_voxel, output ready);
endinterface : lvs_out_if

`default_nettype wire

FILE: rtl/core/lvs_datapath.sv
// Datapath: endpoint registers, error accumulators, step counter and output register.
`default_nettype none

module lvs_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lvs_pkg::lvs_cmd_t cmd_i,
  output      lvs_pkg::lvs_sts_t sts_o,
  input  wire lvs_pkg::point_t   end_i,
  input  wire lvs_pkg::point_t   start_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      lvs_pkg::point_t   out_voxel_o,
  output      logic              out_last_o
);

  localparam int unsigned CB = lvs_pkg::COORD_BITS;
  localparam int unsigned EW = lvs_pkg::ERR_W;
  localparam int unsigned NA = lvs_pkg::NUM_AXES;

  lvs_pkg::coord_t        pos_q  [NA];
  lvs_pkg::coord_t        end_q  [NA];
  lvs_pkg::coord_t        dif_q  [NA];
  logic                   neg_q  [NA];
  logic signed [EW-1:0]   err_q  [NA];
  lvs_pkg::coord_t        amaj_q;
  logic [1:0]             major_q;
  lvs_pkg::coord_t        cnt_q;
  logic                   out_valid_q;
  lvs_pkg::point_t        out_voxel_q;
  logic                   out_last_q;

  // setup terms
  lvs_pkg::coord_t        dif_s  [NA];
  logic                   neg_s  [NA];
  logic                   gt_s   [NA];
  logic                   y_gt_x;
  lvs_pkg::coord_t        amax_xy;
  lvs_pkg::coord_t        amax_s;
  logic [1:0]             major_s;
  logic [1:0]             zeros_s;
  logic                   aligned_s;

  // step terms
  logic signed [EW-1:0]   err_sum [NA];
  logic                   hit     [NA];
  lvs_pkg::coord_t        pos_nx  [NA];

  always_comb begin
    zeros_s = '0;
    for (int i = 0; i < NA; i++) begin
      gt_s[i]  = end_q[i] > pos_q[i];
      dif_s[i] = gt_s[i] ? (end_q[i] - pos_q[i]) : (pos_q[i] - end_q[i]);
      neg_s[i] = !gt_s[i];
      if (dif_s[i] == '0) begin
        zeros_s = zeros_s + 2'd1;
      end
    end
    // ties go to x, then y
    y_gt_x  = dif_s[1] > dif_s[0];
    amax_xy = y_gt_x ? dif_s[1] : dif_s[0];
    if (dif_s[2] > amax_xy) begin
      major_s = lvs_pkg::AXIS_Z;
      amax_s  = dif_s[2];
    end else begin
      major_s = y_gt_x ? lvs_pkg::AXIS_Y : lvs_pkg::AXIS_X;
      amax_s  = amax_xy;
    end
    aligned_s = zeros_s == 2'd2;
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      err_sum[i] = err_q[i] + $signed({2'b00, dif_q[i]});
      hit[i]     = (major_q != 2'(i))
                   && ($signed({err_sum[i], 1'b0}) >= $signed({3'b000, amaj_q}));
      if ((major_q == 2'(i)) || hit[i]) begin
        pos_nx[i] = neg_q[i] ? (pos_q[i] - 1'b1) : (pos_q[i] + 1'b1);
      end else begin
        pos_nx[i] = pos_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q[0] <= start_i.x[CB-1:0];
      pos_q[1] <= start_i.y[CB-1:0];
      pos_q[2] <= start_i.z[CB-1:0];
      end_q[0] <= end_i.x[CB-1:0];
      end_q[1] <= end_i.y[CB-1:0];
      end_q[2] <= end_i.z[CB-1:0];
    end else if (cmd_i.setup) begin
      amaj_q  <= amax_s;
      major_q <= major_s;
      cnt_q   <= amax_s - 1'b1;
      for (int i = 0; i < NA; i++) begin
        dif_q[i] <= dif_s[i];
        err_q[i] <= '0;
        // axis-aligned lines walk upward from the lower endpoint
        if (aligned_s && (major_s == 2'(i))) begin
          neg_q[i] <= 1'b0;
          pos_q[i] <= gt_s[i] ? pos_q[i] : end_q[i];
        end else begin
          neg_q[i] <= neg_s[i];
        end
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 1'b1;
      for (int i = 0; i < NA; i++) begin
        pos_q[i] <= pos_nx[i];
        if (hit[i]) begin
          err_q[i] <= err_sum[i] - $signed({2'b00, amaj_q});
        end else if (major_q != 2'(i)) begin
          err_q[i] <= err_sum[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_voxel_q.x <= lvs_pkg::FIELD_W'(pos_nx[0]);
      out_voxel_q.y <= lvs_pkg::FIELD_W'(pos_nx[1]);
      out_voxel_q.z <= lvs_pkg::FIELD_W'(pos_nx[2]);
      out_last_q    <= cnt_q == lvs_pkg::coord_t'(1);
    end
  end

  assign sts_o.line_empty = amax_s <= lvs_pkg::coord_t'(1);
  assign sts_o.last_step  = cnt_q == lvs_pkg::coord_t'(1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_voxel_o = out_voxel_q;
  assign out_last_o  = out_last_q;

endmodule : lvs_datapath

`default_nettype wire

FILE: rtl/core/lvs_ctrl.sv
// Controller: sequences endpoint capture, setup and voxel stepping.
`default_nettype none

module lvs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      lvs_pkg::lvs_cmd_t cmd_o,
  input  wire lvs_pkg::lvs_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.line_empty ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        // hold while the output register is occupied
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> sts_i.out_free)
    else $error("step issued while output register is full");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && sts_i.last_step) |=> (state_q == ST_IDLE))
    else $error("run did not end after final voxel");

  a_empty_line_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP && sts_i.line_empty) |=> (state_q == ST_IDLE && !$past(cmd_o.step)))
    else $error("empty line entered the stepping phase");

endmodule : lvs_ctrl

`default_nettype wire

FILE: rtl/core/line_voxel_stepper_3d.sv
// Top level: 3D Bresenham voxel stepper between two grid endpoints.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  in_i     | in  | valid/ready  | end_x/y/z, start_x/y/z (6 bits each)
//  out_o    | out | valid/ready  | voxel_x/y/z (6 bits), last_voxel
//
//  An item with largest axis difference D passes through the input transfer and
//  a setup state, then D - 1 stepping states, one voxel each, one error-accumulator
//  step per cycle while the output is not stalled. Equal or adjacent points
//  end after setup and produce nothing. Reset (rst_ni, async, active low) clears
//  the controller and the output valid flag. A stalled output holds stepping;
//  the next input is taken once the last voxel sits in the output register.
`default_nettype none

module line_voxel_stepper_3d (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lvs_in_if.sink    in_i,
  lvs_out_if.source out_o
);

  lvs_pkg::lvs_cmd_t cmd;
  lvs_pkg::lvs_sts_t sts;
  lvs_pkg::point_t   end_pt;
  lvs_pkg::point_t   start_pt;
  lvs_pkg::point_t   voxel;

  // Gather the endpoints of the incoming transfer
  assign end_pt.x   = in_i.end_x;
  assign end_pt.y   = in_i.end_y;
  assign end_pt.z   = in_i.end_z;
  assign start_pt.x = in_i.start_x;
  assign start_pt.y = in_i.start_y;
  assign start_pt.z = in_i.start_z;

  // Controller: capture, setup, then one step per free output slot
  lvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath: coordinates, error terms and the registered result
  lvs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .end_i       (end_pt),
    .start_i     (start_pt),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_voxel_o (voxel),
    .out_last_o  (out_o.last_voxel)
  );

  assign out_o.voxel_x = voxel.x;
  assign out_o.voxel_y = voxel.y;
  assign out_o.voxel_z = voxel.z;

endmodule : line_voxel_stepper_3d

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the 3D line voxel stepper: directed and random lines against a voxel predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_MAX         = (1 << lvs_pkg::COORD_BITS) - 1;
  localparam int COORD_MASK        = COORD_MAX;
  localparam int LONG_STALL_CYCLES = 300;
  // Longest line: input transfer, setup, then 2^COORD_BITS - 2 voxels
  localparam int END_SLACK         = (1 << lvs_pkg::COORD_BITS) + 8;
  localparam int MAX_REPORTS       = 40;
  localparam int RANDOM_LINES      = 160;
  localparam int FULL_RATE_LINES   = 20;
  localparam int BURIED_LINES      = 8;

  // One expected voxel, in the order the block must emit it
  typedef struct packed {
    lvs_pkg::coord_t x;
    lvs_pkg::coord_t y;
    lvs_pkg::coord_t z;
    logic            last;
  } voxel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lvs_in_if  in_ch ();
  lvs_out_if out_ch ();

  line_voxel_stepper_3d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  voxel_t expected_voxels[$];
  int     mismatch_count = 0;

  // Sender pacing: bursts of transfers separated by random gaps
  bit source_idles   = 1'b1;
  int burst_left     = 0;
  // Receiver pacing: random short stalls, plus one long hold-off on request
  bit sink_stalls    = 1'b1;
  bit long_stall_req = 1'b0;
  bit long_stall_ack = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: voxel mismatch: %s", $time, what);
    end
  endtask

  function automatic lvs_pkg::point_t make_point(input int x, input int y, input int z);
    lvs_pkg::point_t p;
    p.x = lvs_pkg::FIELD_W'(x);
    p.y = lvs_pkg::FIELD_W'(y);
    p.z = lvs_pkg::FIELD_W'(z);
    return p;
  endfunction

  function automatic int clamp_coord(input int c);
    if (c < 0) return 0;
    if (c > COORD_MAX) return COORD_MAX;
    return c;
  endfunction

  // Walk the Bresenham line from start toward end and queue every voxel strictly
  // between them. Axis-aligned lines walk upward from the lower endpoint instead.
  function automatic void predict_line_voxels(input lvs_pkg::point_t end_pt,
                                              input lvs_pkg::point_t start_pt);
    int     far_c[3];
    int     pos[3];
    int     span[3];
    int     dir[3];
    int     err[3];
    int     major;
    int     count;
    int     flat_axes;
    int     i;
    int     k;
    voxel_t v;
    far_c[lvs_pkg::AXIS_X] = end_pt.x & COORD_MASK;
    far_c[lvs_pkg::AXIS_Y] = end_pt.y & COORD_MASK;
    far_c[lvs_pkg::AXIS_Z] = end_pt.z & COORD_MASK;
    pos[lvs_pkg::AXIS_X]   = start_pt.x & COORD_MASK;
    pos[lvs_pkg::AXIS_Y]   = start_pt.y & COORD_MASK;
    pos[lvs_pkg::AXIS_Z]   = start_pt.z & COORD_MASK;
    flat_axes = 0;
    for (i = 0; i < lvs_pkg::NUM_AXES; i++) begin
      dir[i]  = (far_c[i] > pos[i]) ? 1 : -1;
      span[i] = (far_c[i] > pos[i]) ? far_c[i] - pos[i] : pos[i] - far_c[i];
      err[i]  = 0;
      if (span[i] == 0) flat_axes++;
    end
    // Ties go to x, then y, then z
    major = lvs_pkg::AXIS_X;
    if (span[lvs_pkg::AXIS_Y] > span[major]) major = lvs_pkg::AXIS_Y;
    if (span[lvs_pkg::AXIS_Z] > span[major]) major = lvs_pkg::AXIS_Z;
    count = span[major] - 1;
    if (flat_axes == 2) begin
      // Minor errors stay zero here, so only the major axis moves
      if (far_c[major] < pos[major]) pos[major] = far_c[major];
      dir[major] = 1;
    end
    for (k = 0; k < count; k++) begin
      pos[major] += dir[major];
      for (i = 0; i < lvs_pkg::NUM_AXES; i++) begin
        if (i != major) begin
          err[i] += span[i];
          if (2 * err[i] >= span[major]) begin
            pos[i] += dir[i];
            err[i] -= span[major];
          end
        end
      end
      v.x    = lvs_pkg::coord_t'(pos[lvs_pkg::AXIS_X] & COORD_MASK);
      v.y    = lvs_pkg::coord_t'(pos[lvs_pkg::AXIS_Y] & COORD_MASK);
      v.z    = lvs_pkg::coord_t'(pos[lvs_pkg::AXIS_Z] & COORD_MASK);
      v.last = (k == count - 1);
      expected_voxels.push_back(v);
    end
  endfunction

  // Offer one line and hold it until the transfer. Valid stays high on return, so
  // a following call can offer the next line back to back.
  task automatic send_line(input lvs_pkg::point_t end_pt, input lvs_pkg::point_t start_pt);
    int gap;
    if (!source_idles) begin
      gap = 0;
    end else if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap        = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.end_x   <= end_pt.x;
    in_ch.end_y   <= end_pt.y;
    in_ch.end_z   <= end_pt.z;
    in_ch.start_x <= start_pt.x;
    in_ch.start_y <= start_pt.y;
    in_ch.start_z <= start_pt.z;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_line_voxels(end_pt, start_pt);
  endtask

  // Drop valid and hold off until every queued voxel has been transferred
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_voxels.size() != 0);
  endtask

  // Mostly general lines, with short, axis-aligned, diagonal and degenerate ones mixed in
  task automatic random_line(output lvs_pkg::point_t end_pt, output lvs_pkg::point_t start_pt);
    int shape;
    int axis;
    int a;
    int b;
    int off;
    int i;
    int c[3];
    int s[3];
    shape = $urandom_range(0, 9);
    axis  = $urandom_range(0, 2);
    a     = $urandom_range(0, COORD_MAX);
    b     = $urandom_range(0, COORD_MAX);
    for (i = 0; i < lvs_pkg::NUM_AXES; i++) begin
      s[i] = $urandom_range(0, COORD_MAX);
      c[i] = $urandom_range(0, COORD_MAX);
      case (shape)
        5, 6: begin
          off  = $urandom_range(0, 8);
          c[i] = clamp_coord(s[i] + off - 4);
        end
        7: begin
          if (i != axis) c[i] = s[i];
        end
        8: begin
          // Equal spans on all axes, direction picked per axis
          if ($urandom_range(0, 1) == 1) begin
            s[i] = COORD_MAX - a;
            c[i] = COORD_MAX - b;
          end else begin
            s[i] = a;
            c[i] = b;
          end
        end
        9: begin
          off  = $urandom_range(0, 2);
          c[i] = clamp_coord(s[i] + off - 1);
        end
        default: ;
      endcase
    end
    end_pt   = make_point(c[lvs_pkg::AXIS_X], c[lvs_pkg::AXIS_Y], c[lvs_pkg::AXIS_Z]);
    start_pt = make_point(s[lvs_pkg::AXIS_X], s[lvs_pkg::AXIS_Y], s[lvs_pkg::AXIS_Z]);
  endtask

  // Equal and adjacent endpoints: nothing may come out
  task automatic test_empty_lines();
    send_line(make_point(0, 0, 0), make_point(0, 0, 0));
    send_line(make_point(63, 63, 63), make_point(63, 63, 63));
    send_line(make_point(1, 1, 1), make_point(0, 0, 0));
    send_line(make_point(62, 63, 63), make_point(63, 63, 63));
    send_line(make_point(5, 4, 6), make_point(6, 5, 5));
    // A real line right behind the empty ones
    send_line(make_point(3, 0, 0), make_point(0, 0, 0));
    wait_drained();
  endtask

  // Axis-aligned lines come out ascending whatever the endpoint order
  task automatic test_axis_lines();
    send_line(make_point(63, 7, 9), make_point(0, 7, 9));
    send_line(make_point(0, 7, 9), make_point(63, 7, 9));
    send_line(make_point(20, 10, 33), make_point(20, 40, 33));
    send_line(make_point(20, 0, 33), make_point(20, 63, 33));
    send_line(make_point(0, 63, 63), make_point(0, 63, 0));
    send_line(make_point(12, 5, 2), make_point(12, 5, 40));
    wait_drained();
  endtask

  // Ties for the major axis, full diagonals, both directions and minor rounding
  task automatic test_slanted_lines();
    send_line(make_point(63, 63, 63), make_point(0, 0, 0));
    send_line(make_point(0, 0, 0), make_point(63, 63, 63));
    send_line(make_point(40, 40, 5), make_point(10, 10, 20));
    send_line(make_point(5, 0, 0), make_point(7, 30, 30));
    send_line(make_point(0, 9, 50), make_point(50, 20, 0));
    send_line(make_point(1, 2, 3), make_point(60, 40, 20));
    // Minor error lands exactly on half the major span
    send_line(make_point(10, 5, 0), make_point(0, 0, 0));
    // One flat axis, two moving
    send_line(make_point(20, 7, 3), make_point(20, 0, 50));
    wait_drained();
  endtask

  task automatic test_random_lines();
    lvs_pkg::point_t end_pt;
    lvs_pkg::point_t start_pt;
    int              n;
    for (n = 0; n < RANDOM_LINES; n++) begin
      random_line(end_pt, start_pt);
      send_line(end_pt, start_pt);
    end
    wait_drained();
  endtask

  // Hold the output off for a long stretch while lines keep coming, so the block
  // fills and stalls its input; then pause the sender until everything drains.
  task automatic test_output_backpressure();
    lvs_pkg::point_t end_pt;
    lvs_pkg::point_t start_pt;
    int              n;
    long_stall_req = !long_stall_req;
    for (n = 0; n < BURIED_LINES; n++) begin
      random_line(end_pt, start_pt);
      send_line(end_pt, start_pt);
    end
    wait_drained();
  endtask

  // Neither side idles: back-to-back transfers with the output always ready
  task automatic test_full_rate();
    lvs_pkg::point_t end_pt;
    lvs_pkg::point_t start_pt;
    int              n;
    source_idles = 1'b0;
    sink_stalls  = 1'b0;
    for (n = 0; n < FULL_RATE_LINES; n++) begin
      random_line(end_pt, start_pt);
      send_line(end_pt, start_pt);
    end
    wait_drained();
    source_idles = 1'b1;
    sink_stalls  = 1'b1;
  endtask

  // Receiver: short random stalls, or always ready, plus the long hold-off
  initial begin : voxel_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req != long_stall_ack) begin
        long_stall_ack = long_stall_req;
        hold_left      = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!sink_stalls) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every transferred voxel against the oldest expected one
  always @(posedge clk_i) begin : voxel_checker
    voxel_t got;
    voxel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.x    = out_ch.voxel_x;
      got.y    = out_ch.voxel_y;
      got.z    = out_ch.voxel_z;
      got.last = out_ch.last_voxel;
      if (expected_voxels.size() == 0) begin
        report_mismatch($sformatf("unexpected voxel (%0d,%0d,%0d) last=%0b",
                                  got.x, got.y, got.z, got.last));
      end else begin
        want = expected_voxels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.last !== want.last) begin
          report_mismatch($sformatf("got (%0d,%0d,%0d) last=%0b, want (%0d,%0d,%0d) last=%0b",
                                    got.x, got.y, got.z, got.last,
                                    want.x, want.y, want.z, want.last));
        end
      end
    end
  end

  // Stop a hung run; the slowest correct run stays well under this
  initial begin : run_limit
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : test_sequence
    rst_ni = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    in_ch.end_z   <= '0;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.start_z <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lines();
    test_axis_lines();
    test_slanted_lines();
    test_random_lines();
    test_output_backpressure();
    test_full_rate();

    // Let any stray voxel surface before the verdict
    repeat (END_SLACK) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : tb_top

FILE: files.f
rtl/core/lvs_pkg.sv
rtl/core/lvs_if.sv
rtl/core/lvs_datapath.sv
rtl/core/lvs_ctrl.sv
rtl/core/line_voxel_stepper_3d.sv
test/tb_top.sv
